>>> sv/c2p_pkg.sv
// Shared constants, arctangent table and side-band type for the rectangular-to-polar converter
`timescale 1ns / 1ps

package c2p_pkg;

    // Default sizes
    localparam int DATA_WIDTH_DEF = 16;
    localparam int ITERATIONS_DEF = 16;

    // Datapath formats
    localparam int GUARD_BITS  = 8;
    localparam int TABLE_LEN   = 24;
    localparam int Z_W         = 25;
    localparam int ANGLE_W     = 16;
    localparam int ANGLE_LIMIT = 23040;

    // Gain correction: K = GAIN_K / 2^GAIN_SHIFT
    localparam int GAIN_K     = 636751;
    localparam int GAIN_SHIFT = 20;
    localparam int K_W        = 20;
    localparam int SPLIT_W    = 21;

    // atan(2^-i) in degrees, scaled by 2^16
    localparam logic signed [Z_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
        25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
        25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
        25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
        25'sd917,     25'sd458,     25'sd229,    25'sd115,
        25'sd57,      25'sd29,      25'sd14,     25'sd7,
        25'sd4,       25'sd2,       25'sd1,      25'sd0
    };

    // Special-case flags that travel with each item
    typedef struct packed {
        logic origin;
        logic vertical;
        logic y_neg;
    } c2p_side_t;

endpackage

>>> sv/c2p_stage.sv
// One CORDIC vectoring micro-rotation with its pipeline register
`timescale 1ns / 1ps

module c2p_stage #(
    parameter int W   = 27,
    parameter int DW  = 16,
    parameter int IDX = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [W-1:0]           in_x,
    input  logic signed [W-1:0]           in_y,
    input  logic signed [c2p_pkg::Z_W-1:0] in_z,
    input  c2p_pkg::c2p_side_t            in_side,
    input  logic [DW-1:0]                 in_abs_y,
    output logic                          out_valid,
    output logic signed [W-1:0]           out_x,
    output logic signed [W-1:0]           out_y,
    output logic signed [c2p_pkg::Z_W-1:0] out_z,
    output c2p_pkg::c2p_side_t            out_side,
    output logic [DW-1:0]                 out_abs_y
);
    import c2p_pkg::*;

    logic signed [W-1:0]   xs;
    logic signed [W-1:0]   ys;
    logic signed [W-1:0]   x_next;
    logic signed [W-1:0]   y_next;
    logic signed [Z_W-1:0] z_next;
    logic                  valid_reg;
    logic signed [W-1:0]   x_reg;
    logic signed [W-1:0]   y_reg;
    logic signed [Z_W-1:0] z_reg;
    c2p_side_t             side_reg;
    logic [DW-1:0]         abs_y_reg;

    assign xs = in_x >>> IDX;
    assign ys = in_y >>> IDX;

    // Rotate towards the positive x axis, steering by the sign of y
    always_comb begin
        if (!in_y[W-1]) begin
            x_next = in_x + ys;
            y_next = in_y - xs;
            z_next = in_z + ATAN_TABLE[IDX];
        end else begin
            x_next = in_x - ys;
            y_next = in_y + xs;
            z_next = in_z - ATAN_TABLE[IDX];
        end
    end

    // Advance the valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // Advance the payload
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            side_reg  <= in_side;
            abs_y_reg <= in_abs_y;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;
    assign out_abs_y = abs_y_reg;

endmodule

>>> sv/c2p_gain.sv
// Gain correction, rounding, clamping and special-case selection over two stages
`timescale 1ns / 1ps

module c2p_gain #(
    parameter int W  = 27,
    parameter int DW = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [W-1:0]             in_x,
    input  logic signed [c2p_pkg::Z_W-1:0]  in_z,
    input  c2p_pkg::c2p_side_t              in_side,
    input  logic [DW-1:0]                   in_abs_y,
    output logic                            out_valid,
    output logic [DW-1:0]                   out_magnitude,
    output logic signed [c2p_pkg::ANGLE_W-1:0] out_angle,
    output logic                            out_undef
);
    import c2p_pkg::*;

    localparam int XPAD_W    = 2 * SPLIT_W;
    localparam int PROD_W    = SPLIT_W + K_W;
    localparam int SUM_W     = XPAD_W + K_W + 1;
    localparam int RND_SHIFT = GAIN_SHIFT + GUARD_BITS;
    localparam int MAGW_W    = SUM_W - RND_SHIFT;
    localparam int ZS_W      = Z_W + 1;

    localparam logic [PROD_W-1:0]      GAIN_C  = PROD_W'(GAIN_K);
    localparam logic [SUM_W-1:0]       ROUND_C = SUM_W'(64'd1 << (RND_SHIFT - 1));
    localparam logic signed [ZS_W-1:0] LIM_P   = ZS_W'(ANGLE_LIMIT);
    localparam logic signed [ZS_W-1:0] LIM_N   = -LIM_P;
    localparam logic signed [ZS_W-1:0] ZRND    = ZS_W'(128);

    logic [XPAD_W-1:0]           xu;
    logic [PROD_W-1:0]           prod_lo_next;
    logic [PROD_W-1:0]           prod_hi_next;
    logic signed [ZS_W-1:0]      za;
    logic signed [ZS_W-1:0]      zs;
    logic signed [ANGLE_W-1:0]   angle_next;

    logic                        valid_a_reg;
    logic [PROD_W-1:0]           prod_lo_reg;
    logic [PROD_W-1:0]           prod_hi_reg;
    logic signed [ANGLE_W-1:0]   angle_a_reg;
    c2p_side_t                   side_a_reg;
    logic [DW-1:0]               abs_y_a_reg;

    logic [SUM_W-1:0]            sum;
    logic [MAGW_W-1:0]           mag_w;
    logic [DW-1:0]               mag_next;

    logic                        valid_b_reg;
    logic [DW-1:0]               mag_reg;
    logic signed [ANGLE_W-1:0]   angle_b_reg;
    logic                        undef_reg;

    // Stage A: clamp x at zero, split it into two halves and multiply each by K
    always_comb begin
        xu           = in_x[W-1] ? '0 : XPAD_W'(in_x[W-2:0]);
        prod_lo_next = PROD_W'(xu[SPLIT_W-1:0]) * GAIN_C;
        prod_hi_next = PROD_W'(xu[XPAD_W-1:SPLIT_W]) * GAIN_C;
    end

    // Stage A: round the angle to Q8.8, clamp and apply the axis cases
    always_comb begin
        za = ZS_W'(in_z) + ZRND;
        zs = za >>> 8;
        if (in_side.origin) begin
            angle_next = '0;
        end else if (in_side.vertical) begin
            angle_next = in_side.y_neg ? ANGLE_W'(LIM_N) : ANGLE_W'(LIM_P);
        end else if (zs > LIM_P) begin
            angle_next = ANGLE_W'(LIM_P);
        end else if (zs < LIM_N) begin
            angle_next = ANGLE_W'(LIM_N);
        end else begin
            angle_next = ANGLE_W'(zs);
        end
    end

    // Stage B: join the partial products, round and saturate the magnitude
    always_comb begin
        sum   = (SUM_W'(prod_hi_reg) << SPLIT_W) + SUM_W'(prod_lo_reg) + ROUND_C;
        mag_w = sum[SUM_W-1:RND_SHIFT];
        if (side_a_reg.origin) begin
            mag_next = '0;
        end else if (side_a_reg.vertical) begin
            mag_next = abs_y_a_reg;
        end else if (mag_w[MAGW_W-1:DW] != '0) begin
            mag_next = '1;
        end else begin
            mag_next = mag_w[DW-1:0];
        end
    end

    // Advance the valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else if (en) begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_lo_reg <= prod_lo_next;
            prod_hi_reg <= prod_hi_next;
            angle_a_reg <= angle_next;
            side_a_reg  <= in_side;
            abs_y_a_reg <= in_abs_y;
            mag_reg     <= mag_next;
            angle_b_reg <= angle_a_reg;
            undef_reg   <= side_a_reg.origin;
        end
    end

    assign out_valid     = valid_b_reg;
    assign out_magnitude = mag_reg;
    assign out_angle     = angle_b_reg;
    assign out_undef     = undef_reg;

endmodule

>>> sv/c2p_outbuf.sv
// Output register with a one-entry skid stage that holds the pipeline on a stall
`timescale 1ns / 1ps

module c2p_outbuf #(
    parameter int DW = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               p_valid,
    input  logic [DW-1:0]                      p_magnitude,
    input  logic signed [c2p_pkg::ANGLE_W-1:0] p_angle,
    input  logic                               p_undef,
    output logic                               pipe_en,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [DW-1:0]                      m_magnitude,
    output logic signed [c2p_pkg::ANGLE_W-1:0] m_angle_deg,
    output logic                               m_angle_undefined
);
    import c2p_pkg::*;

    logic                      m_valid_reg;
    logic                      skid_valid_reg;
    logic [DW-1:0]             mag_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    logic                      undef_reg;
    logic [DW-1:0]             skid_mag_reg;
    logic signed [ANGLE_W-1:0] skid_angle_reg;
    logic                      skid_undef_reg;
    logic                      out_free;

    // The pipeline moves only while the skid entry is empty
    assign pipe_en  = !skid_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Track output and skid occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (p_valid) begin
            if (out_free) begin
                m_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Load the output from the skid entry first, else from the pipeline
    always_ff @(posedge aclk) begin
        if (skid_valid_reg && m_ready) begin
            mag_reg   <= skid_mag_reg;
            angle_reg <= skid_angle_reg;
            undef_reg <= skid_undef_reg;
        end else if (!skid_valid_reg && p_valid && out_free) begin
            mag_reg   <= p_magnitude;
            angle_reg <= p_angle;
            undef_reg <= p_undef;
        end
        if (!skid_valid_reg && p_valid && !out_free) begin
            skid_mag_reg   <= p_magnitude;
            skid_angle_reg <= p_angle;
            skid_undef_reg <= p_undef;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_magnitude       = mag_reg;
    assign m_angle_deg       = angle_reg;
    assign m_angle_undefined = undef_reg;

    // The skid entry only fills behind a held output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry occupied while output register empty");

    a_skid_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_ready && p_valid))
        else $error("skid entry filled without a stalled output");

endmodule

>>> sv/cartesian_to_polar.sv
// Throughput: one item per cycle while the skid entry is empty; one register stage per CORDIC
// micro-rotation, plus an input fold stage, two gain-correction stages and the output register.
// An output stall fills a one-entry skid stage; s_ready is registered and drops while it is full.
// Reset: synchronous, active-low aresetn clears every valid bit; no memories need clearing.
`timescale 1ns / 1ps

module cartesian_to_polar #(
    parameter int DATA_WIDTH = c2p_pkg::DATA_WIDTH_DEF,
    parameter int ITERATIONS = c2p_pkg::ITERATIONS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [DATA_WIDTH-1:0]       s_x_coord,
    input  logic signed [DATA_WIDTH-1:0]       s_y_coord,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [DATA_WIDTH-1:0]              m_magnitude,
    output logic signed [c2p_pkg::ANGLE_W-1:0] m_angle_deg,
    output logic                               m_angle_undefined
);
    import c2p_pkg::*;

    localparam int DW       = DATA_WIDTH;
    localparam int W        = DW + GUARD_BITS + 3;
    localparam int NUM_ITER = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;

    logic                  en;
    logic signed [W-1:0]   x_ext;
    logic signed [W-1:0]   y_ext;
    logic signed [W-1:0]   x_fold;
    logic signed [W-1:0]   y_fold;
    c2p_side_t             side_next;
    logic [DW-1:0]         abs_y_next;

    logic [NUM_ITER:0]     valid_pipe;
    logic signed [W-1:0]   x_pipe     [NUM_ITER+1];
    logic signed [W-1:0]   y_pipe     [NUM_ITER+1];
    logic signed [Z_W-1:0] z_pipe     [NUM_ITER+1];
    c2p_side_t             side_pipe  [NUM_ITER+1];
    logic [DW-1:0]         abs_y_pipe [NUM_ITER+1];

    logic                  valid0_reg;
    logic signed [W-1:0]   x0_reg;
    logic signed [W-1:0]   y0_reg;
    c2p_side_t             side0_reg;
    logic [DW-1:0]         abs_y0_reg;

    logic                      g_valid;
    logic [DW-1:0]             g_magnitude;
    logic signed [ANGLE_W-1:0] g_angle;
    logic                      g_undef;

    assign s_ready = en;

    // Fold a point with negative x through the origin and add guard bits
    always_comb begin
        x_ext  = W'(s_x_coord);
        y_ext  = W'(s_y_coord);
        x_fold = s_x_coord[DW-1] ? -x_ext : x_ext;
        y_fold = s_x_coord[DW-1] ? -y_ext : y_ext;
        side_next.origin   = (s_x_coord == '0) && (s_y_coord == '0);
        side_next.vertical = (s_x_coord == '0) && (s_y_coord != '0);
        side_next.y_neg    = s_y_coord[DW-1];
        abs_y_next = s_y_coord[DW-1] ? DW'(-s_y_coord) : DW'(s_y_coord);
    end

    // Input stage valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid0_reg <= 1'b0;
        end else if (en) begin
            valid0_reg <= s_valid;
        end
    end

    // Input stage payload
    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg     <= x_fold <<< GUARD_BITS;
            y0_reg     <= y_fold <<< GUARD_BITS;
            side0_reg  <= side_next;
            abs_y0_reg <= abs_y_next;
        end
    end

    assign valid_pipe[0] = valid0_reg;
    assign x_pipe[0]     = x0_reg;
    assign y_pipe[0]     = y0_reg;
    assign z_pipe[0]     = '0;
    assign side_pipe[0]  = side0_reg;
    assign abs_y_pipe[0] = abs_y0_reg;

    // One register stage per micro-rotation
    for (genvar i = 0; i < NUM_ITER; i++) begin : g_iter
        c2p_stage #(
            .W   (W),
            .DW  (DW),
            .IDX (i)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (valid_pipe[i]),
            .in_x      (x_pipe[i]),
            .in_y      (y_pipe[i]),
            .in_z      (z_pipe[i]),
            .in_side   (side_pipe[i]),
            .in_abs_y  (abs_y_pipe[i]),
            .out_valid (valid_pipe[i+1]),
            .out_x     (x_pipe[i+1]),
            .out_y     (y_pipe[i+1]),
            .out_z     (z_pipe[i+1]),
            .out_side  (side_pipe[i+1]),
            .out_abs_y (abs_y_pipe[i+1])
        );
    end

    c2p_gain #(
        .W  (W),
        .DW (DW)
    ) u_gain (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (valid_pipe[NUM_ITER]),
        .in_x          (x_pipe[NUM_ITER]),
        .in_z          (z_pipe[NUM_ITER]),
        .in_side       (side_pipe[NUM_ITER]),
        .in_abs_y      (abs_y_pipe[NUM_ITER]),
        .out_valid     (g_valid),
        .out_magnitude (g_magnitude),
        .out_angle     (g_angle),
        .out_undef     (g_undef)
    );

    c2p_outbuf #(
        .DW (DW)
    ) u_outbuf (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .p_valid           (g_valid),
        .p_magnitude       (g_magnitude),
        .p_angle           (g_angle),
        .p_undef           (g_undef),
        .pipe_en           (en),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_magnitude       (m_magnitude),
        .m_angle_deg       (m_angle_deg),
        .m_angle_undefined (m_angle_undefined)
    );

    // Origin results carry zero magnitude and zero angle
    a_origin_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_angle_undefined |-> (m_magnitude == '0) && (m_angle_deg == '0))
        else $error("undefined angle without zero result");

    // The folded angle never leaves -90..+90 degrees
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_angle_deg <= ANGLE_W'(ANGLE_LIMIT))
                 && (m_angle_deg >= -ANGLE_W'(ANGLE_LIMIT)))
        else $error("angle outside the folded range");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the rectangular-to-polar CORDIC converter
`timescale 1ns / 1ps

module testbench;

    localparam int DW    = 16;
    localparam int ITERS = 16;
    localparam int AW    = c2p_pkg::ANGLE_W;
    localparam int N_RANDOM = 700;
    localparam int DRAIN_CYCLES = ITERS + 24;

    // atan(2^-i) in degrees, scaled by 2^16
    localparam longint ATAN_DEG_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic [DW-1:0]        magnitude;
        logic signed [AW-1:0] angle;
        logic                 undefined;
    } polar_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [DW-1:0] s_x_coord;
    logic signed [DW-1:0] s_y_coord;
    logic                 m_valid;
    logic                 m_ready;
    logic [DW-1:0]        m_magnitude;
    logic signed [AW-1:0] m_angle_deg;
    logic                 m_angle_undefined;

    // Suppress idling on both sides while set
    bit quiet = 1'b0;

    // Work out radius and folded angle of one point
    function automatic polar_t polar_of(logic signed [DW-1:0] xc, logic signed [DW-1:0] yc);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint ang;
        longint unsigned mag;
        polar_t r;
        x = xc;
        y = yc;
        r.undefined = 1'b0;
        if (x == 0 && y == 0) begin
            mag = 0;
            ang = 0;
            r.undefined = 1'b1;
        end else if (x == 0) begin
            mag = (y < 0) ? -y : y;
            ang = (y > 0) ? c2p_pkg::ANGLE_LIMIT : -c2p_pkg::ANGLE_LIMIT;
        end else begin
            z = 0;
            // Mirror through the origin so that x is positive; y/x is unchanged
            if (x < 0) begin
                x = -x;
                y = -y;
            end
            x = x * 256;
            y = y * 256;
            for (int i = 0; i < ITERS && i < 24; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_DEG_Q16[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_DEG_Q16[i];
                end
            end
            if (x < 0)
                x = 0;
            mag = (longint'(x) * 636751 + (64'd1 << 27)) >> 28;
            ang = (z + 128) >>> 8;
            if (ang > c2p_pkg::ANGLE_LIMIT)
                ang = c2p_pkg::ANGLE_LIMIT;
            if (ang < -c2p_pkg::ANGLE_LIMIT)
                ang = -c2p_pkg::ANGLE_LIMIT;
        end
        if (mag > (64'd1 << DW) - 1)
            mag = (64'd1 << DW) - 1;
        r.magnitude = mag[DW-1:0];
        r.angle     = ang[AW-1:0];
        return r;
    endfunction

    class polar_scoreboard;
        polar_t awaited[$];
        int     n_points;
        int     n_checked;
        int     n_errors;

        function void note_point(logic signed [DW-1:0] x, logic signed [DW-1:0] y);
            awaited.push_back(polar_of(x, y));
            n_points++;
        endfunction

        function void check_result(logic [DW-1:0] mag, logic signed [AW-1:0] ang, logic undef);
            polar_t e;
            if (awaited.size() == 0) begin
                $error("unexpected result: magnitude %0d angle_deg %0d angle_undefined %0b",
                       mag, ang, undef);
                n_errors++;
                return;
            end
            e = awaited.pop_front();
            n_checked++;
            if (mag !== e.magnitude) begin
                $error("magnitude: expected %0d, actual %0d", e.magnitude, mag);
                n_errors++;
            end
            if (ang !== e.angle) begin
                $error("angle_deg: expected %0d, actual %0d", e.angle, ang);
                n_errors++;
            end
            if (undef !== e.undefined) begin
                $error("angle_undefined: expected %0b, actual %0b", e.undefined, undef);
                n_errors++;
            end
        endfunction
    endclass

    polar_scoreboard sb = new();

    cartesian_to_polar #(
        .DATA_WIDTH(DW),
        .ITERATIONS(ITERS)
    ) u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_x_coord         (s_x_coord),
        .s_y_coord         (s_y_coord),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_magnitude       (m_magnitude),
        .m_angle_deg       (m_angle_deg),
        .m_angle_undefined (m_angle_undefined)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic bit idle_roll();
        return !quiet && ($urandom_range(99) < 14);
    endfunction

    // Pick a coordinate from the corners of the range, or anything
    function automatic logic signed [DW-1:0] edge_coord();
        case ($urandom_range(6))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            5: return 32767;
            default: return DW'($urandom_range(65535));
        endcase
    endfunction

    // Offer one point, idling first at random, and hold it until accepted
    task automatic send_point(input logic signed [DW-1:0] x, input logic signed [DW-1:0] y);
        while (idle_roll()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_x_coord <= x;
        s_y_coord <= y;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_point(x, y);
    endtask

    // Accept and check results, stalling at random
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_magnitude, m_angle_deg, m_angle_undefined);
            m_ready <= !idle_roll();
        end
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        int                   d;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_x_coord <= '0;
        s_y_coord <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Origin, vertical axis, horizontal axis, the corners and the unit diagonals
        send_point(0, 0);
        send_point(0, 1);
        send_point(0, -1);
        send_point(0, 32767);
        send_point(0, -32768);
        send_point(1, 0);
        send_point(-1, 0);
        send_point(32767, 0);
        send_point(-32768, 0);
        send_point(32767, 32767);
        send_point(-32768, -32768);
        send_point(-32768, 32767);
        send_point(32767, -32768);
        send_point(1, 1);
        send_point(-1, 1);
        send_point(1, -1);
        send_point(-1, -1);
        // Steep points drive the angle towards the clamp; a shallow and a diagonal point follow
        send_point(1, 32767);
        send_point(1, -32768);
        send_point(-1, 32767);
        send_point(-32768, 1);
        send_point(256, -256);
        send_point(-300, 12345);

        for (int n = 0; n < N_RANDOM; n++) begin
            quiet = (n >= 250 && n < 400);
            d = $urandom_range(99);
            if (d < 40) begin
                x = DW'($urandom_range(65535));
                y = DW'($urandom_range(65535));
            end else if (d < 60) begin
                x = DW'($urandom_range(2047) - 1024);
                y = DW'($urandom_range(2047) - 1024);
            end else if (d < 70) begin
                // Points on an axis, now and then the origin
                x = DW'($urandom_range(65535));
                y = DW'($urandom_range(65535));
                case ($urandom_range(4))
                    0: begin
                        x = 0;
                        y = 0;
                    end
                    1, 2: x = 0;
                    default: y = 0;
                endcase
            end else if (d < 85) begin
                // Near the diagonals
                x = DW'($urandom_range(65535));
                y = DW'(x + $urandom_range(16) - 8);
                if ($urandom_range(1))
                    y = -y;
            end else begin
                x = edge_coord();
                y = edge_coord();
            end
            send_point(x, y);
        end
        quiet = 1'b0;
        s_valid <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.awaited.size() != 0) begin
            $error("%0d results never arrived", sb.awaited.size());
            sb.n_errors++;
        end
        $display("Sent %0d points: origin, both axes, corners, mirrored negative x, random spread.",
                 sb.n_points);
        $display("Compared %0d results field by field, %0d mismatches.", sb.n_checked,
                 sb.n_errors);
        if (sb.n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
